// ===== rtl/rgb_convolution_3x3_assert.svh =====
// Assertion helpers used by the checker of the 3x3 convolution block.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef RGB_CONVOLUTION_3X3_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_ASSERT_SVH

// Same-cycle implication
`define RGBC3_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RGBC3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rgbc3_pkg.sv =====
package rgbc3_pkg;

	// Default line length of the line buffer
	localparam int MAX_WIDTH_DEF = 512;

	// Field widths
	localparam int CHAN_W  = 8;
	localparam int POS_W   = 9;
	localparam int COEF_W  = 16;
	localparam int ROWC_W  = 48;
	localparam int SIZE_W  = 10;
	localparam int BIAS_W  = 10;
	localparam int FRAC_W  = 10;
	localparam int IDX_W   = 3;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 48;
	localparam int LINE_W  = 48;

	// Arithmetic widths: 9-bit signed pixel times s5.10 coefficient,
	// three taps per column, three columns plus the bias
	localparam int PROD_W  = 25;
	localparam int CSUM_W  = 27;
	localparam int ACC_W   = 30;

	// Largest supported image height
	localparam int MAX_HEIGHT = 512;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_COEF_TOP = 3'd0;
	localparam logic [IDX_W-1:0] REG_COEF_MID = 3'd1;
	localparam logic [IDX_W-1:0] REG_COEF_BOT = 3'd2;
	localparam logic [IDX_W-1:0] REG_BIAS     = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd4;
	localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd5;

	// Pixel: red in the low byte, then green, then blue
	typedef logic [IN_W-1:0] pix_t;
	// Window column: index 0 is the top row, 2 the bottom row
	typedef pix_t [2:0] col_t;
	// Coefficients of one kernel column, same row order
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [2:0] coef_col_t;
	// Per-channel column sums: index 0 red, 1 green, 2 blue
	typedef logic signed [CSUM_W-1:0] csum_t;
	typedef csum_t [2:0] sums_t;

	// Position and frame flag carried with an item down the pipeline
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} meta_t;

endpackage

// ===== rtl/rgbc3_line_buf.sv =====
module rgbc3_line_buf
	import rgbc3_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [LINE_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [LINE_W-1:0] wr_data
);

	logic [LINE_W-1:0] mem [DEPTH];
	logic [LINE_W-1:0] rd_data_q;

	// Write one column's pair of past pixels
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while no new item arrives
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/rgbc3_cell.sv =====
module rgbc3_cell
	import rgbc3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift,
	input  logic      adv,
	input  col_t      col_in,
	input  coef_col_t coef,
	output col_t      col_out,
	output sums_t     sums
);

	col_t                     col_q;
	logic signed [PROD_W-1:0] prod_d  [3][3];
	logic signed [PROD_W-1:0] prod_s3 [3][3];
	sums_t                    sum_d;
	sums_t                    sum_s4;

	// Window column: take the neighbor's column when an item moves in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// Three taps times three channels, pixel taken as a positive signed value
	always_comb begin
		logic signed [PROD_W-1:0] px_x;
		logic signed [PROD_W-1:0] cf_x;
		for (int t = 0; t < 3; t++) begin
			for (int ch = 0; ch < 3; ch++) begin
				px_x = PROD_W'($signed({1'b0, col_q[t][CHAN_W*ch +: CHAN_W]}));
				cf_x = PROD_W'($signed(coef[t]));
				prod_d[t][ch] = px_x * cf_x;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= prod_d;
		end
	end

	// Column sum per channel
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = CSUM_W'(prod_s3[0][ch]) + CSUM_W'(prod_s3[1][ch])
				+ CSUM_W'(prod_s3[2][ch]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4 <= sum_d;
		end
	end

	assign sums = sum_s4;

endmodule

// ===== rtl/rgb_convolution_3x3.sv =====
// Streaming 3x3 convolution of an RGB raster image. Pixels enter on the s_ side
// in raster order, one item per clock while the output skid entry is free; for every
// pixel at row r >= 2 and column c >= 2 the block emits the filtered interior pixel
// (r-1, c-1) on the m_ side, tagged with its position, with m_tlast on the last
// interior pixel of the frame. Each channel is the sum of nine pixel times s5.10
// coefficient products plus bias_level, clamped to 0..255 with the fraction dropped;
// the consumer paints the one-pixel border itself. A pixel passes the stage 1,
// window, product, column sum, accumulator and output registers. The sustained
// rate of one pixel per clock is set by the single line buffer memory (MAX_WIDTH
// x 48 bits, one read and one write port per clock) and by the three-cell window
// chain, which shifts once per pixel. A two-entry output stage keeps input flowing
// while a result waits. The line buffer needs no clearing after reset. Configuration
// registers take effect on the next pixel and are to be written between frames.
module rgb_convolution_3x3
	import rgbc3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Pixel input
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,    // in_red, in_green, in_blue
	// Filtered output
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,    // out_red, out_green, out_blue, out_row, out_col, zero pad
	output logic              m_tlast,    // frame_last
	// Configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [ROWC_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = (CW > SIZE_W ? CW : SIZE_W) + 1;

	// Configuration registers
	logic [ROWC_W-1:0]        coef_top_q, coef_mid_q, coef_bot_q;
	logic signed [BIAS_W-1:0] bias_q;
	logic [SIZE_W-1:0]        width_q, height_q;

	// Position counters
	logic [CW-1:0]    col_q;
	logic [POS_W-1:0] row_q;

	logic [CW-1:0]    w_last;
	logic [POS_W-1:0] h_last;
	logic [XW-1:0]    wid_x;
	logic             accept;
	logic             adv;
	logic             at_col_end;
	logic             at_row_end;
	logic [XW-1:0]    col_x;
	logic [XW-1:0]    col_m1;
	meta_t            meta_d;

	// Pipeline stages
	logic             v_s1, emit_s1;
	pix_t             pix_s1;
	logic [CW-1:0]    addr_s1;
	meta_t            meta_s1;
	logic             v_s2, v_s3, v_s4, v_s5;
	meta_t            meta_s2, meta_s3, meta_s4, meta_s5;
	logic signed [ACC_W-1:0] acc_s5 [3];
	logic signed [ACC_W-1:0] acc_d  [3];

	logic [LINE_W-1:0] lb_rdata;
	col_t              new_col;
	col_t              cell_col [3];
	sums_t             cell_sum [3];
	coef_col_t         cell_coef [3];

	// Output stage and skid entry
	logic [OUT_W-1:0] out_data_q, skid_data_q, push_data;
	logic             out_last_q, skid_last_q;
	logic             out_valid_q, skid_valid_q;
	logic             push, pop;

	function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-FRAC_W-1:0] q;
		q = a[ACC_W-1:FRAC_W];
		if (a < 0) begin
			clamp_chan = '0;
		end else if (q > (ACC_W-FRAC_W)'(255)) begin
			clamp_chan = '1;
		end else begin
			clamp_chan = q[CHAN_W-1:0];
		end
	endfunction

	// Register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= '0;
			coef_mid_q <= '0;
			coef_bot_q <= '0;
			bias_q     <= '0;
			width_q    <= SIZE_W'(512);
			height_q   <= SIZE_W'(512);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_TOP: coef_top_q <= cfg_data;
				REG_COEF_MID: coef_mid_q <= cfg_data;
				REG_COEF_BOT: coef_bot_q <= cfg_data;
				REG_BIAS:     bias_q     <= cfg_data[BIAS_W-1:0];
				REG_WIDTH:    width_q    <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:   height_q   <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturated last column and last row
	always_comb begin
		wid_x = XW'(width_q);
		if (wid_x < XW'(3)) begin
			w_last = CW'(2);
		end else if (wid_x > XW'(MAX_WIDTH)) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(wid_x - XW'(1));
		end
		if (height_q < SIZE_W'(3)) begin
			h_last = POS_W'(2);
		end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
			h_last = POS_W'(MAX_HEIGHT - 1);
		end else begin
			h_last = POS_W'(height_q - SIZE_W'(1));
		end
	end

	// The whole pipeline moves while the skid entry is free
	assign adv      = !skid_valid_q;
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	assign at_col_end = (col_q >= w_last);
	assign at_row_end = (row_q >= h_last);

	always_comb begin
		col_x       = XW'(col_q);
		col_m1      = col_x - XW'(1);
		meta_d.row  = row_q - POS_W'(1);
		meta_d.col  = col_m1[POS_W-1:0];
		meta_d.last = at_col_end && at_row_end;
	end

	// Advance the raster position on each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_col_end) begin
				col_q <= '0;
				row_q <= at_row_end ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: pixel waits for its line buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (adv) begin
			v_s1    <= accept;
			emit_s1 <= accept && (row_q >= POS_W'(2)) && (col_q >= CW'(2));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= s_tdata;
			addr_s1 <= col_q;
			meta_s1 <= meta_d;
		end
	end

	rgbc3_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lb_rdata),
		.wr_en   (adv && v_s1),
		.wr_addr (addr_s1),
		.wr_data ({lb_rdata[IN_W-1:0], pix_s1})
	);

	// New rightmost window column: two rows back, one row back, this pixel
	assign new_col = {pix_s1, lb_rdata[IN_W-1:0], lb_rdata[LINE_W-1:IN_W]};

	// Chain of window cells, rightmost fed from the line buffer
	for (genvar k = 0; k < 3; k++) begin : g_cell
		assign cell_coef[k] = {coef_bot_q[COEF_W*k +: COEF_W],
			coef_mid_q[COEF_W*k +: COEF_W], coef_top_q[COEF_W*k +: COEF_W]};
		if (k == 2) begin : g_head
			rgbc3_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (adv && v_s1),
				.adv     (adv),
				.col_in  (new_col),
				.coef    (cell_coef[k]),
				.col_out (cell_col[k]),
				.sums    (cell_sum[k])
			);
		end else begin : g_body
			rgbc3_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (adv && v_s1),
				.adv     (adv),
				.col_in  (cell_col[k+1]),
				.coef    (cell_coef[k]),
				.col_out (cell_col[k]),
				.sums    (cell_sum[k])
			);
		end
	end

	// Stages 2 to 5 carry only items that produce a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
		end
	end

	// Add the three column sums and the scaled bias
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			acc_d[ch] = ACC_W'(cell_sum[0][ch]) + ACC_W'(cell_sum[1][ch])
				+ ACC_W'(cell_sum[2][ch]) + (ACC_W'(bias_q) <<< FRAC_W);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s5 <= acc_d;
		end
	end

	// Clamp and pack the result
	assign push_data = {{(OUT_W - 3*CHAN_W - 2*POS_W){1'b0}}, meta_s5.col, meta_s5.row,
		clamp_chan(acc_s5[2]), clamp_chan(acc_s5[1]), clamp_chan(acc_s5[0])};
	assign push = adv && v_s5;
	assign pop  = out_valid_q && m_tready;

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
				out_last_q <= skid_last_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= push_data;
				skid_last_q <= meta_s5.last;
			end else begin
				out_data_q <= push_data;
				out_last_q <= meta_s5.last;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/rgbc3_check.sv =====
`include "rgb_convolution_3x3_assert.svh"

module rgbc3_check
	import rgbc3_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tlast
);

	// Held result keeps its valid
	`RGBC3_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// Held result keeps its payload
	`RGBC3_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

	// Input only stops when a result is waiting at the output
	`RGBC3_ASSERT_IMPL(a_back_press, !s_tready, m_tvalid, "input stalled with no result pending")

	// Results are interior pixels: never row zero
	`RGBC3_ASSERT_IMPL(a_row_interior, m_tvalid, m_tdata[32:24] != 9'd0, "border row emitted")

endmodule

bind rgb_convolution_3x3 rgbc3_check u_check (.*);
